// ===== hw/rtl/athk_pkg.sv =====
// Shared types and constants for the angular triangular-kernel histogram.
`default_nettype none

package athk_pkg;

	// Operation codes carried on the input tuser
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Field widths
	localparam int OP_W     = 2;
	localparam int ANGLE_W  = 16;
	localparam int BIN_W    = 9;
	localparam int ACC_W    = 40;
	localparam int SPREAD_W = 12;
	localparam int FRAC_W   = 16;
	localparam int WEIGHT_W = FRAC_W + 1;

	// Stream widths, padded to whole bytes
	localparam int IN_W  = 32;
	localparam int OUT_W = 48;

	// Histogram geometry
	localparam int NUM_BINS = 360;

	// Shift-subtract steps per divider run (angle bits or weight fraction bits)
	localparam int DIV_STEPS = 16;

	localparam logic [SPREAD_W-1:0] SPREAD_RESET = 12'd704;
	localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = {1'b1, {FRAC_W{1'b0}}};

	// Start request for the shared divider
	typedef struct packed {
		logic               load;
		logic [ANGLE_W-1:0] feed;
	} div_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/athk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module athk_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 360
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/athk_div.sv =====
// Shared shift-subtract divider: one quotient bit per cycle.
`default_nettype none

module athk_div #(
	parameter int DW = 14
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire athk_pkg::div_req_t                  req,
	input  wire logic [DW-1:0]                       rem_init,
	input  wire logic [DW-1:0]                       divisor,
	output logic                                     busy,
	output logic [athk_pkg::DIV_STEPS-1:0]           quotient,
	output logic [DW-1:0]                            remainder
);

	localparam int CNT_W = $clog2(athk_pkg::DIV_STEPS + 1);

	logic                              busy_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [DW-1:0]                     rem_q;
	logic [DW-1:0]                     div_q;
	logic [athk_pkg::ANGLE_W-1:0]      feed_q;
	logic [athk_pkg::DIV_STEPS-1:0]    quo_q;

	logic [DW:0] trial;
	logic [DW:0] trial_sub;
	logic        ge;
	logic [DW-1:0] rem_next;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial     = {rem_q, feed_q[athk_pkg::ANGLE_W-1]};
		trial_sub = trial - {1'b0, div_q};
		ge        = (trial >= {1'b0, div_q});
		rem_next  = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.load) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(athk_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (req.load) begin
			rem_q  <= rem_init;
			div_q  <= divisor;
			feed_q <= req.feed;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			feed_q <= {feed_q[athk_pkg::ANGLE_W-2:0], 1'b0};
			quo_q  <= {quo_q[athk_pkg::DIV_STEPS-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/angular_triangular_kernel_histogram_unit.sv =====
// Top level of the angular triangular-kernel histogram: sequencer, datapath and bin store.
//
// Input items arrive on s_tvalid/s_tready with the op code in s_tuser and the
// event angle and bin index in s_tdata. Each item gives exactly one result on
// m_tvalid/m_tready: the bin content for a read (zero for an index past the last
// bin), zero for add, clear and op 3. The spread register is written through cfg_we/cfg_wdata; the user
// is to write it only while the block is idle, which the block itself does not enforce.
// One item is worked on at a time; s_tready is high only in the idle state. Work per item,
// done with the shared shift-subtract divider and a read-modify-write of the bin RAM:
//   add:   fold the angle in the divider, then for each of the two centers
//          visit 2*ceil(spread/64)+1 bins; a bin inside the spread gets its
//          weight from a divider run (weight one at the center) and is written
//          back, others are skipped; the default spread is 11 degrees.
//   read:  read the bin.   clear: one bin written per cycle.
// After reset the block sweeps zeros through all 360 bins before
// it raises s_tready. A result waits in the output register while m_tready is
// low; the block can take the next item meanwhile but will not finish it until
// the waiting result is taken.
`default_nettype none

module angular_triangular_kernel_histogram_unit #(
	parameter int MAX_HALF_SPAN   = 45,
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// spread register write
	input  wire logic                              cfg_we,
	input  wire logic [athk_pkg::SPREAD_W-1:0]     cfg_wdata,
	// input items
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [athk_pkg::IN_W-1:0]         s_tdata,  // [15:0] event_angle, [24:16] bin_index
	input  wire logic [athk_pkg::OP_W-1:0]         s_tuser,  // [1:0] op
	// result items
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [athk_pkg::OUT_W-1:0]             m_tdata   // [39:0] bin_value, [40] done_res
);

	// Angle geometry
	localparam int DEG_UNIT   = 1 << ANGLE_FRAC_BITS;
	localparam int HALF_TURN  = 180 * DEG_UNIT;
	localparam int FULL_TURN  = 360 * DEG_UNIT;
	localparam int AW         = $clog2(FULL_TURN);
	localparam int HT_W       = $clog2(HALF_TURN + 1);
	localparam int DIV_W      = (HT_W > athk_pkg::SPREAD_W) ? HT_W : athk_pkg::SPREAD_W;
	localparam int FOLD_K     = (1 << (athk_pkg::ANGLE_W - 1)) % HALF_TURN;
	localparam int ROUND_OFS  = DEG_UNIT / 2;
	localparam int SPAN_CAP   = MAX_HALF_SPAN * DEG_UNIT;
	localparam int CAP_CLIP   = (SPAN_CAP > 4095) ? 4095 : SPAN_CAP;
	localparam int HALF_W     = $clog2(MAX_HALF_SPAN + 1);
	localparam int CNT_W      = HALF_W + 1;
	localparam int BW         = athk_pkg::BIN_W;
	localparam int SW         = athk_pkg::SPREAD_W;

	// Sequencer states
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_FOLD  = 4'd2;
	localparam logic [3:0] S_ROUND = 4'd3;
	localparam logic [3:0] S_START = 4'd4;
	localparam logic [3:0] S_DIFF  = 4'd5;
	localparam logic [3:0] S_ABS   = 4'd6;
	localparam logic [3:0] S_FOLDD = 4'd7;
	localparam logic [3:0] S_CHK   = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_WR    = 4'd10;
	localparam logic [3:0] S_NEXT  = 4'd11;
	localparam logic [3:0] S_RD1   = 4'd12;
	localparam logic [3:0] S_RD2   = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	localparam logic [BW-1:0] LAST_BIN = BW'(athk_pkg::NUM_BINS - 1);

	// Control registers
	logic [3:0]        state_q;
	logic              init_q;
	logic              pass_q;
	logic [BW-1:0]     idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SW-1:0]     spread_q;
	logic              m_valid_q;

	// Datapath registers
	logic [SW-1:0]                  s_q;
	logic [AW-1:0]                  c_q;
	logic [BW-1:0]                  rc_q;
	logic [HALF_W-1:0]              half_q;
	logic signed [AW:0]             diff_q;
	logic [AW-1:0]                  ad_q;
	logic [AW-1:0]                  d_q;
	logic [athk_pkg::WEIGHT_W-1:0]  w_q;
	logic [athk_pkg::ACC_W-1:0]     res_q;
	logic [athk_pkg::ACC_W-1:0]     bin_q;

	// Combinational helpers
	logic                              accept;
	logic [athk_pkg::OP_W-1:0]         op;
	logic [athk_pkg::ANGLE_W-1:0]      angle;
	logic [BW-1:0]                     bin_index;
	logic [SW-1:0]                     s_eff;
	logic [AW-1:0]                     fold_r;
	logic [AW-1:0]                     fold_f;
	logic [AW:0]                       rnd_sum;
	logic [AW:0]                       rc_full;
	logic [BW-1:0]                     rc_val;
	logic [SW:0]                       half_sum;
	logic [BW-1:0]                     start_idx;
	logic [AW-1:0]                     bin_pos;
	logic signed [AW:0]                diff_neg;
	logic                              d_in_span;
	logic                              chk_load;
	logic [BW-1:0]                     idx_inc;
	logic [athk_pkg::ACC_W:0]          acc_sum;
	logic [athk_pkg::ACC_W-1:0]        acc_new;

	// Divider and RAM hookup
	athk_pkg::div_req_t                div_req;
	logic [DIV_W-1:0]                  div_rem_init;
	logic [DIV_W-1:0]                  div_divisor;
	logic                              div_busy;
	logic [athk_pkg::DIV_STEPS-1:0]    div_quo;
	logic [DIV_W-1:0]                  div_rem;
	logic                              ram_we;
	logic [athk_pkg::ACC_W-1:0]        ram_wdata;
	logic [athk_pkg::ACC_W-1:0]        ram_rdata;

	assign accept    = s_tvalid && s_tready;
	assign op        = s_tuser;
	assign angle     = s_tdata[athk_pkg::ANGLE_W-1:0];
	assign bin_index = s_tdata[athk_pkg::ANGLE_W +: BW];

	always_comb begin
		// Clamp the spread to one angle unit .. MAX_HALF_SPAN degrees, capped at 4095 units
		if (spread_q == '0) begin
			s_eff = SW'(1);
		end else if (spread_q > SW'(CAP_CLIP)) begin
			s_eff = SW'(CAP_CLIP);
		end else begin
			s_eff = spread_q;
		end

		// Undo the +32768 bias of the folding division (floored modulo)
		fold_r = AW'(div_rem);
		if (fold_r >= AW'(FOLD_K)) begin
			fold_f = fold_r - AW'(FOLD_K);
		end else begin
			fold_f = fold_r + AW'(HALF_TURN - FOLD_K);
		end

		// Round the center to a whole degree, half up, modulo 360
		rnd_sum = (AW + 1)'(c_q) + (AW + 1)'(ROUND_OFS);
		rc_full = rnd_sum >> ANGLE_FRAC_BITS;
		rc_val  = (rc_full == (AW + 1)'(athk_pkg::NUM_BINS)) ? '0 : BW'(rc_full);

		// Bin reach: ceil(spread) in whole degrees
		half_sum = (SW + 1)'(s_q) + (SW + 1)'(DEG_UNIT - 1);

		// First bin of the window, wrapped below zero
		if (rc_q >= BW'(half_q)) begin
			start_idx = rc_q - BW'(half_q);
		end else begin
			start_idx = rc_q + BW'(athk_pkg::NUM_BINS) - BW'(half_q);
		end

		bin_pos   = AW'(idx_q) << ANGLE_FRAC_BITS;
		diff_neg  = -diff_q;
		d_in_span = (d_q <= AW'(s_q));
		chk_load  = (state_q == S_CHK) && d_in_span && (d_q != '0);
		idx_inc   = (idx_q == LAST_BIN) ? '0 : idx_q + 1'b1;

		// Saturating accumulate
		acc_sum = {1'b0, ram_rdata} + (athk_pkg::ACC_W + 1)'(w_q);
		acc_new = acc_sum[athk_pkg::ACC_W] ? athk_pkg::ACC_MAX : acc_sum[athk_pkg::ACC_W-1:0];
	end

	// Divider requests: angle fold at accept, weight division per bin inside the spread off the center
	always_comb begin
		div_req.load = (accept && (op == athk_pkg::OP_ADD)) || chk_load;
		if (state_q == S_IDLE) begin
			div_req.feed = {~angle[athk_pkg::ANGLE_W-1], angle[athk_pkg::ANGLE_W-2:0]};
			div_rem_init = '0;
			div_divisor  = DIV_W'(HALF_TURN);
		end else begin
			div_req.feed = '0;
			div_rem_init = DIV_W'(s_q - SW'(d_q));
			div_divisor  = DIV_W'(s_q);
		end
	end

	athk_div #(
		.DW (DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.rem_init  (div_rem_init),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign ram_we    = (state_q == S_WR) || (state_q == S_CLR);
	assign ram_wdata = (state_q == S_CLR) ? '0 : acc_new;

	athk_ram #(
		.WIDTH (athk_pkg::ACC_W),
		.DEPTH (athk_pkg::NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			init_q    <= 1'b1;
			pass_q    <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
			spread_q  <= athk_pkg::SPREAD_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				spread_q <= cfg_wdata;
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					idx_q <= idx_inc;
					if (idx_q == LAST_BIN) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_OUT;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (op)
							athk_pkg::OP_ADD: begin
								state_q <= S_FOLD;
							end
							athk_pkg::OP_READ: begin
								idx_q   <= bin_index;
								state_q <= S_RD1;
							end
							athk_pkg::OP_CLEAR: begin
								idx_q   <= '0;
								state_q <= S_CLR;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_FOLD: begin
					pass_q <= 1'b0;
					if (!div_busy) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= S_START;
				end
				S_START: begin
					idx_q   <= start_idx;
					cnt_q   <= {half_q, 1'b0};
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					state_q <= S_ABS;
				end
				S_ABS: begin
					state_q <= S_FOLDD;
				end
				S_FOLDD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!d_in_span) begin
						state_q <= S_NEXT;
					end else if (d_q == '0) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (cnt_q == '0) begin
						if (!pass_q) begin
							pass_q  <= 1'b1;
							state_q <= S_ROUND;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						idx_q   <= idx_inc;
						state_q <= S_DIFF;
					end
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					s_q   <= s_eff;
					res_q <= '0;
				end
			end
			S_FOLD: begin
				if (!div_busy) begin
					c_q <= fold_f;
				end
			end
			S_ROUND: begin
				rc_q   <= rc_val;
				half_q <= HALF_W'(half_sum >> ANGLE_FRAC_BITS);
			end
			S_DIFF: begin
				diff_q <= $signed({1'b0, bin_pos}) - $signed({1'b0, c_q});
			end
			S_ABS: begin
				ad_q <= diff_q[AW] ? diff_neg[AW-1:0] : diff_q[AW-1:0];
			end
			S_FOLDD: begin
				d_q <= (ad_q > AW'(HALF_TURN)) ? AW'(FULL_TURN) - ad_q : ad_q;
			end
			S_CHK: begin
				w_q <= athk_pkg::WEIGHT_ONE;
			end
			S_DIV: begin
				if (!div_busy) begin
					w_q <= athk_pkg::WEIGHT_W'(div_quo);
				end
			end
			S_NEXT: begin
				// Second center sits half a turn further
				if (cnt_q == '0 && !pass_q) begin
					c_q <= c_q + AW'(HALF_TURN);
				end
			end
			S_RD2: begin
				res_q <= (idx_q <= LAST_BIN) ? ram_rdata : '0;
			end
			S_OUT: begin
				if (!m_valid_q || m_tready) begin
					bin_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(athk_pkg::OUT_W - athk_pkg::ACC_W - 1){1'b0}}, 1'b1, bin_q};

endmodule

`default_nettype wire

// ===== hw/rtl/athk_check.sv =====
// Port-level checker for the angular triangular-kernel histogram, bound to the top level.
`default_nettype none

module athk_check (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [athk_pkg::OUT_W-1:0]    m_tdata
);

	// One item at a time: an accepted item drops ready
	property p_busy_after_accept;
		@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready;
	endproperty
	a_busy_after_accept: assert property (p_busy_after_accept)
		else $error("s_tready stayed high after an item was accepted");

	// A new result comes only out of a busy block
	property p_result_from_work;
		@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready);
	endproperty
	a_result_from_work: assert property (p_result_from_work)
		else $error("result appeared while the block was idle");

	// Every result reports completion
	property p_done_flag;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[athk_pkg::ACC_W];
	endproperty
	a_done_flag: assert property (p_done_flag)
		else $error("result item without done_res");

	// Hold a stalled result
	property p_hold_stalled;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
	endproperty
	a_hold_stalled: assert property (p_hold_stalled)
		else $error("stalled result item changed or dropped");

endmodule

bind angular_triangular_kernel_histogram_unit athk_check u_athk_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
